[hw/rtl/wrs_pkg.sv]
`timescale 1ns / 1ps

package wrs_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int CHANNEL_BITS  = 16;
  localparam int NUM_CH        = 3;
  localparam int PIX_BITS      = NUM_CH * CHANNEL_BITS;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int SIZE_BITS     = 11;
  localparam int DAMP_BITS     = 16;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int SUM_BITS      = CHANNEL_BITS + 2;
  localparam int PROD_BITS     = SUM_BITS + DAMP_BITS;
  localparam int ROUND_SHIFT   = 17;
  localparam int SCALED_BITS   = PROD_BITS + 1 - ROUND_SHIFT;
  localparam int LINE_DEPTH    = 2 * MAX_WIDTH;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0]      pix_t;
  typedef logic [COL_BITS-1:0]     col_t;
  typedef logic [ROW_BITS-1:0]     row_t;
  typedef logic [SIZE_BITS-1:0]    size_t;
  typedef logic [DAMP_BITS-1:0]    damp_t;
  typedef logic [SUM_BITS-1:0]     sum_t;
  typedef logic [PROD_BITS-1:0]    prod_t;
  typedef logic [PROD_BITS:0]      rnd_t;
  typedef logic [SCALED_BITS-1:0]  scaled_t;
  typedef logic [COL_BITS:0]       line_addr_t;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_DAMPING      = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam damp_t   DAMPING_RESET = damp_t'(65503);
  localparam size_t   WIDTH_RESET   = size_t'(1000);
  localparam size_t   HEIGHT_RESET  = size_t'(750);
  localparam size_t   MIN_SIZE      = size_t'(3);
  localparam size_t   WIDTH_LIMIT   = size_t'(MAX_WIDTH);
  localparam size_t   HEIGHT_LIMIT  = size_t'(MAX_HEIGHT);
  localparam chan_t   CH_ONE        = chan_t'(1) << (CHANNEL_BITS - 1);
  localparam rnd_t    ROUND_HALF    = rnd_t'(1) << (ROUND_SHIFT - 1);
  localparam scaled_t SCALED_ONE    = scaled_t'(CH_ONE);

endpackage

[hw/rtl/wrs_ram.sv]
`timescale 1ns / 1ps

module wrs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/water_ripple_stencil_unit.sv]
`timescale 1ns / 1ps

// A result passes the s1, s2 and output registers after the pixel that releases it is taken.
// Throughput: one pixel per cycle while out_ready holds; on the last row of a frame each pixel
// releases two results, so the single output port holds the next pixel until both are taken.
// Reset restores the register defaults and clears the raster position and all pipeline valids;
// the line stores are not cleared and need no sweep.
module water_ripple_stencil_unit import wrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  chan_t                    prev_red,
  input  chan_t                    prev_green,
  input  chan_t                    prev_blue,
  input  chan_t                    older_red,
  input  chan_t                    older_green,
  input  chan_t                    older_blue,
  output logic                     out_valid,
  input  logic                     out_ready,
  output row_t                     out_row,
  output col_t                     out_col,
  output chan_t                    new_red,
  output chan_t                    new_green,
  output chan_t                    new_blue,
  output logic                     frame_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_ADDR_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  damp_t damping;
  size_t frame_width;
  size_t frame_height;
  size_t w_eff;
  size_t h_eff;

  row_t  row_count;
  col_t  col_count;
  logic  col_over;
  size_t row_pre;
  row_t  r_cur;
  col_t  c_cur;
  logic  last_col;
  logic  last_row;
  logic  in_accept;
  logic  slot;

  pix_t       in_prev;
  pix_t       in_older;
  line_addr_t a_raddr;
  line_addr_t b_raddr;
  pix_t       a_rd;
  pix_t       b_rd;
  pix_t       o_rd;

  logic  s1_valid;
  row_t  s1_row;
  col_t  s1_col;
  logic  s1_has_above;
  logic  s1_border;
  logic  s1_has_self;
  logic  s1_last;
  pix_t  s1_south;
  pix_t  s1_older;
  pix_t  mid_reg;
  pix_t  west_reg;
  pix_t  mid_cur;
  sum_t  diff [NUM_CH];
  logic  s1_move;

  logic  s2_valid;
  row_t  s2_row;
  col_t  s2_col;
  logic  s2_border;
  logic  p_above;
  logic  p_self;
  logic  s2_last;
  sum_t  s2_diff [NUM_CH];
  pix_t  s2_older_above;
  pix_t  s2_older_self;
  pix_t  above_val;
  logic  s2_load_out;
  logic  s2_done;
  logic  s2_free;
  logic  can_load_out;

  pix_t  out_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping      <= DAMPING_RESET;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DAMPING:      damping      <= cfg_data[DAMP_BITS-1:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[SIZE_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < MIN_SIZE) begin
      w_eff = MIN_SIZE;
    end else if (frame_width > WIDTH_LIMIT) begin
      w_eff = WIDTH_LIMIT;
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < MIN_SIZE) begin
      h_eff = MIN_SIZE;
    end else if (frame_height > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = frame_height;
    end
  end

  // wrap a position left beyond a resized frame
  assign col_over = size_t'(col_count) >= w_eff;
  assign row_pre  = col_over ? size_t'(row_count) + size_t'(1) : size_t'(row_count);
  assign r_cur    = (row_pre >= h_eff) ? '0 : row_pre[ROW_BITS-1:0];
  assign c_cur    = col_over ? '0 : col_count;
  assign last_col = size_t'(c_cur) == (w_eff - size_t'(1));
  assign last_row = size_t'(r_cur) == (h_eff - size_t'(1));
  assign slot     = r_cur[0];

  assign in_ready  = !s1_valid || s1_move;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : r_cur + row_t'(1);
      end else begin
        col_count <= c_cur + col_t'(1);
        row_count <= r_cur;
      end
    end
  end

  assign in_prev[0]  = prev_red;
  assign in_prev[1]  = prev_green;
  assign in_prev[2]  = prev_blue;
  assign in_older[0] = older_red;
  assign in_older[1] = older_green;
  assign in_older[2] = older_blue;

  // port A fetches the row above at column 0 on a row start, else two rows up
  assign a_raddr = (c_cur == '0) ? {~slot, col_t'(0)} : {slot, c_cur};
  assign b_raddr = {~slot, c_cur + col_t'(1)};

  wrs_ram #(.WIDTH(PIX_BITS), .DEPTH(LINE_DEPTH)) u_line_a (
    .clk   (clk),
    .we    (in_accept),
    .waddr ({slot, c_cur}),
    .wdata (in_prev),
    .re    (in_accept),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  wrs_ram #(.WIDTH(PIX_BITS), .DEPTH(LINE_DEPTH)) u_line_b (
    .clk   (clk),
    .we    (in_accept),
    .waddr ({slot, c_cur}),
    .wdata (in_prev),
    .re    (in_accept),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  wrs_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (in_accept),
    .waddr (c_cur),
    .wdata (in_older),
    .re    (in_accept),
    .raddr (c_cur),
    .rdata (o_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_row       <= r_cur;
      s1_col       <= c_cur;
      s1_has_above <= r_cur != '0;
      s1_border    <= (r_cur == row_t'(1)) || (c_cur == '0) || last_col;
      s1_has_self  <= last_row;
      s1_last      <= last_col;
      s1_south     <= in_prev;
      s1_older     <= in_older;
    end
  end

  assign mid_cur = (s1_col == '0) ? a_rd : mid_reg;

  always_comb begin
    sum_t pos;
    sum_t neg;
    for (int k = 0; k < NUM_CH; k++) begin
      pos = sum_t'(a_rd[k]) + sum_t'(s1_south[k]) + sum_t'(west_reg[k]) + sum_t'(b_rd[k]);
      neg = {1'b0, o_rd[k], 1'b0};
      diff[k] = (pos > neg) ? pos - neg : '0;
    end
  end

  assign can_load_out = !out_valid || out_ready;
  assign s2_load_out  = s2_valid && can_load_out;
  assign s2_done      = s2_load_out && !(p_above && p_self);
  assign s2_free      = !s2_valid || s2_done;
  assign s1_move      = s1_valid && s2_free;

  // advance the row-above window: west takes the centre, centre takes the east fetch
  always_ff @(posedge clk) begin
    if (s1_move) begin
      west_reg <= mid_cur;
      mid_reg  <= b_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      p_above  <= 1'b0;
      p_self   <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= s1_has_above || s1_has_self;
      p_above  <= s1_has_above;
      p_self   <= s1_has_self;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end else if (s2_load_out) begin
      p_above <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_row         <= s1_row;
      s2_col         <= s1_col;
      s2_border      <= s1_border;
      s2_last        <= s1_last;
      s2_older_above <= o_rd;
      s2_older_self  <= s1_older;
      for (int k = 0; k < NUM_CH; k++) begin
        s2_diff[k] <= diff[k];
      end
    end
  end

  always_comb begin
    prod_t   prod;
    rnd_t    rnd;
    scaled_t scaled;
    for (int k = 0; k < NUM_CH; k++) begin
      prod   = prod_t'(s2_diff[k]) * prod_t'(damping);
      rnd    = rnd_t'(prod) + ROUND_HALF;
      scaled = rnd[PROD_BITS:ROUND_SHIFT];
      if (s2_border) begin
        above_val[k] = s2_older_above[k];
      end else if (scaled > SCALED_ONE) begin
        above_val[k] = CH_ONE;
      end else begin
        above_val[k] = scaled[CHANNEL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load_out) begin
      out_col <= s2_col;
      if (p_above) begin
        out_row    <= s2_row - row_t'(1);
        out_pix    <= above_val;
        frame_last <= 1'b0;
      end else begin
        out_row    <= s2_row;
        out_pix    <= s2_older_self;
        frame_last <= s2_last;
      end
    end
  end

  assign new_red   = out_pix[0];
  assign new_green = out_pix[1];
  assign new_blue  = out_pix[2];

endmodule
